// ===== rtl/catmull_rom_arc_length_path_macros.svh =====
// Assertion macros for the Catmull-Rom arc length path checker.
// Used by cral_chk; no other dependencies.
`ifndef CATMULL_ROM_ARC_LENGTH_PATH_MACROS_SVH
`define CATMULL_ROM_ARC_LENGTH_PATH_MACROS_SVH

// Property checked only outside of reset.
`define CRAL_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cral: property violated");

// Property checked at every edge, reset included.
`define CRAL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cral: property violated");

`endif

// ===== rtl/cral_pkg.sv =====
// Shared types and constants of the Catmull-Rom arc length path.
// No dependencies.
package cral_pkg;

    typedef struct packed {
        logic               operation;
        logic [3:0]         point_index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [23:0]        arc_position;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] curve_x;
        logic signed [15:0] curve_y;
        logic signed [19:0] slope_x;
        logic signed [19:0] slope_y;
        logic [3:0]         segment;
        logic               beyond_end;
    } t_out_item;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int   CFG_W       = 5;
    localparam logic CFG_POINTS  = 1'b0;
    localparam logic CFG_SAMPLES = 1'b1;

    localparam int          LEN_W    = 24;
    localparam logic [23:0] LEN_MAX  = 24'hFFFFFF;
    localparam int          T_W      = 17;
    localparam logic [16:0] T_ONE    = 17'h10000;
    localparam logic [3:0]  SAMP_MAX = 4'd8;
    localparam logic [4:0]  PTS_RST  = 5'd4;
    localparam logic [3:0]  SAMP_RST = 4'd4;

endpackage

// ===== rtl/cral_in_if.sv =====
// Input channel of the Catmull-Rom arc length path: valid, ready, item.
// Depends on cral_pkg.
interface cral_in_if;
    import cral_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cral_out_if.sv =====
// Output channel of the Catmull-Rom arc length path: valid, ready, result.
// Depends on cral_pkg.
interface cral_out_if;
    import cral_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cral_ram.sv =====
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module cral_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/catmull_rom_arc_length_path.sv =====
// Catmull-Rom path evaluated by arc length; one item in flight, ready only when idle.
// Reset: a clearing pass over all MAX_POINTS addresses zeroes the point and length RAMs, ready low.
// Query: walks the segment lengths, divides for t, evaluates point and gradient through the
// shared MAC, then registers the result.
// Write: each affected segment (up to 4; all of them on a samples change) is measured over
// 2^k chords: curve samples through the MAC, two squares, a 27-step square root, one accumulate.
module catmull_rom_arc_length_path #(
    parameter int MAX_POINTS  = 16,
    parameter int COORD_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [cral_pkg::CFG_W-1:0] i_cfg_data,
    cral_in_if.sink                    i_in,
    cral_out_if.source                 o_out
);
    import cral_pkg::*;

    localparam int AW        = $clog2(MAX_POINTS);
    localparam int SEG_COUNT = MAX_POINTS - 3;
    localparam int ACC_W     = COORD_WIDTH + 42;
    localparam int PW        = ACC_W - 33;
    localparam int DW        = PW + 1;
    localparam int SQ_W      = 2 * DW + 2;
    localparam int R_W       = DW + 1;
    localparam int REM_W     = R_W + 3;
    localparam int SUM_W     = ((R_W > LEN_W) ? R_W : LEN_W) + 1;
    localparam int PROD_W    = COORD_WIDTH + 24;
    localparam int Q_W       = 40;
    localparam int SC_W      = $clog2(R_W + 1);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_SEG  = 5'd2;
    localparam logic [4:0] S_T2   = 5'd3;
    localparam logic [4:0] S_T3   = 5'd4;
    localparam logic [4:0] S_W    = 5'd5;
    localparam logic [4:0] S_MAC  = 5'd6;
    localparam logic [4:0] S_EVD  = 5'd7;
    localparam logic [4:0] S_SQ1  = 5'd8;
    localparam logic [4:0] S_SQ2  = 5'd9;
    localparam logic [4:0] S_SQRT = 5'd10;
    localparam logic [4:0] S_ACC  = 5'd11;
    localparam logic [4:0] S_WRD  = 5'd12;
    localparam logic [4:0] S_WCMP = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_FIN  = 5'd15;

    localparam logic MODE_LEN = 1'b0;
    localparam logic MODE_QRY = 1'b1;

    logic [4:0]             r_state;
    logic [AW-1:0]          r_clr;
    logic [4:0]             r_pts;
    logic [3:0]             r_slog;
    logic                   r_ov;
    t_out_item              r_od;
    t_out_item              r_res;
    logic                   r_mode;
    logic                   r_grad;
    logic                   r_src;
    logic [AW-1:0]          r_seg;
    logic [AW-1:0]          r_hi;
    logic [AW-1:0]          r_last;
    logic [1:0]             r_jj;
    logic [1:0]             r_ph;
    logic [8:0]             r_j;
    logic [T_W-1:0]         r_t;
    logic [32:0]            r_tt;
    logic [32:0]            r_ttt;
    logic signed [Q_W-1:0]  r_q [4];
    logic signed [ACC_W-1:0] r_ax;
    logic signed [ACC_W-1:0] r_ay;
    logic signed [PW-1:0]   r_px;
    logic signed [PW-1:0]   r_py;
    logic signed [DW-1:0]   r_dx;
    logic signed [DW-1:0]   r_dy;
    logic [SQ_W-1:0]        r_sq;
    logic [REM_W-1:0]       r_rem;
    logic [R_W-1:0]         r_root;
    logic [SC_W-1:0]        r_scnt;
    logic [LEN_W-1:0]       r_lacc;
    logic [LEN_W-1:0]       r_pos;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W:0]         r_drem;
    logic [15:0]            r_qt;
    logic [4:0]             r_dcnt;

    // RAM ports
    logic                   ctrl_we;
    logic [AW-1:0]          ctrl_waddr;
    logic [COORD_WIDTH-1:0] ctrl_wx, ctrl_wy, ctrl_rx, ctrl_ry;
    logic                   len_we;
    logic [AW-1:0]          len_waddr;
    logic [LEN_W-1:0]       len_wdata, len_rdata;

    cral_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(ctrl_we), .i_waddr(ctrl_waddr), .i_wdata(ctrl_wx),
        .i_raddr(r_seg + AW'(r_jj)), .o_rdata(ctrl_rx));
    cral_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(ctrl_we), .i_waddr(ctrl_waddr), .i_wdata(ctrl_wy),
        .i_raddr(r_seg + AW'(r_jj)), .o_rdata(ctrl_ry));
    cral_ram #(.WIDTH(LEN_W), .DEPTH(MAX_POINTS)) u_ram_len (
        .i_clk(i_clk), .i_we(len_we), .i_waddr(len_waddr), .i_wdata(len_wdata),
        .i_raddr(r_seg), .o_rdata(len_rdata));

    // Input handshake and decode
    logic          cfg_samp, in_acc, wr_acc, qry_acc, idx_ok;
    logic [AW-1:0] idx_a, wr_lo, wr_hi, q_last;
    logic [AW:0]   p_eff;

    assign cfg_samp   = i_cfg_we && (i_cfg_idx == CFG_SAMPLES);
    assign i_in.ready = (r_state == S_IDLE) && !cfg_samp;
    assign in_acc     = i_in.valid && i_in.ready;
    assign wr_acc     = in_acc && (i_in.data.operation == OP_WRITE);
    assign qry_acc    = in_acc && (i_in.data.operation == OP_QUERY);
    assign idx_ok     = int'(i_in.data.point_index) < MAX_POINTS;
    assign idx_a      = AW'(i_in.data.point_index);

    always_comb begin
        wr_lo = (int'(i_in.data.point_index) >= 3) ? idx_a - AW'(3) : '0;
        wr_hi = (int'(i_in.data.point_index) < SEG_COUNT - 1) ? idx_a : AW'(SEG_COUNT - 1);
        if (int'(r_pts) < 4) begin
            p_eff = (AW + 1)'(4);
        end else if (int'(r_pts) > MAX_POINTS) begin
            p_eff = (AW + 1)'(MAX_POINTS);
        end else begin
            p_eff = (AW + 1)'(r_pts);
        end
        q_last = AW'(p_eff - (AW + 1)'(4));
    end

    // Sample spacing
    logic [3:0] k_eff;
    logic [8:0] n_samp;
    logic [8:0] j_next;
    logic [T_W-1:0] t_next;

    assign k_eff  = (r_slog > SAMP_MAX) ? SAMP_MAX : r_slog;
    assign n_samp = 9'(9'd1 << k_eff);
    assign j_next = r_j + 9'd1;
    assign t_next = T_W'({j_next, 16'b0} >> k_eff);

    // Blend weights, signed Q7.32
    logic signed [Q_W-1:0] tt_s, ttt_s, t32_s, one_s;
    logic signed [Q_W-1:0] w [4];

    assign tt_s  = signed'({7'b0, r_tt});
    assign ttt_s = signed'({7'b0, r_ttt});
    assign t32_s = signed'({7'b0, r_t, 16'b0});
    assign one_s = 40'sh01_0000_0000;

    always_comb begin
        if (!r_grad) begin
            w[0] = -ttt_s + 40'sd2 * tt_s - t32_s;
            w[1] = 40'sd3 * ttt_s - 40'sd5 * tt_s + 40'sd2 * one_s;
            w[2] = -(40'sd3 * ttt_s) + 40'sd4 * tt_s + t32_s;
            w[3] = ttt_s - tt_s;
        end else begin
            w[0] = -(40'sd3 * tt_s) + 40'sd4 * t32_s - one_s;
            w[1] = 40'sd9 * tt_s - 40'sd10 * t32_s;
            w[2] = -(40'sd9 * tt_s) + 40'sd8 * t32_s + one_s;
            w[3] = 40'sd3 * tt_s - 40'sd2 * t32_s;
        end
    end

    // MAC: weight split into low 16 unsigned bits and signed upper part
    logic signed [23:0]          wsel;
    logic signed [COORD_WIDTH-1:0] xs, ys;
    logic signed [PROD_W-1:0]    prodx, prody;
    logic signed [ACC_W-1:0]     addx, addy;

    assign wsel  = (r_ph == 2'd1) ? signed'({8'b0, r_q[r_jj][15:0]}) : r_q[r_jj][39:16];
    assign xs    = signed'(ctrl_rx);
    assign ys    = signed'(ctrl_ry);
    assign prodx = xs * wsel;
    assign prody = ys * wsel;
    assign addx  = (r_ph == 2'd2) ? (ACC_W'(prodx) <<< 16) : ACC_W'(prodx);
    assign addy  = (r_ph == 2'd2) ? (ACC_W'(prody) <<< 16) : ACC_W'(prody);

    // Round half up of the Q.32 sum halved
    logic signed [ACC_W-1:0] ax_r, ay_r;
    logic signed [PW-1:0]    rx, ry;

    assign ax_r = r_ax + signed'(ACC_W'(64'h1_0000_0000));
    assign ay_r = r_ay + signed'(ACC_W'(64'h1_0000_0000));
    assign rx   = ax_r[ACC_W-1:33];
    assign ry   = ay_r[ACC_W-1:33];

    logic signed [15:0] sat_x16, sat_y16;
    logic signed [19:0] sat_x20, sat_y20;

    always_comb begin
        if (longint'(rx) > 64'sd32767)       sat_x16 = 16'sh7FFF;
        else if (longint'(rx) < -64'sd32768) sat_x16 = -16'sh8000;
        else                                 sat_x16 = 16'(rx);
        if (longint'(ry) > 64'sd32767)       sat_y16 = 16'sh7FFF;
        else if (longint'(ry) < -64'sd32768) sat_y16 = -16'sh8000;
        else                                 sat_y16 = 16'(ry);
        if (longint'(rx) > 64'sd524287)       sat_x20 = 20'sh7FFFF;
        else if (longint'(rx) < -64'sd524288) sat_x20 = -20'sh80000;
        else                                  sat_x20 = 20'(rx);
        if (longint'(ry) > 64'sd524287)       sat_y20 = 20'sh7FFFF;
        else if (longint'(ry) < -64'sd524288) sat_y20 = -20'sh80000;
        else                                  sat_y20 = 20'(ry);
    end

    // Chord squares, square root step, length accumulate
    logic signed [2*DW-1:0] sqx, sqy;
    logic [REM_W-1:0]       rem_sh, trial;
    logic                   sq_ge;
    logic [SUM_W-1:0]       lsum;
    logic [LEN_W-1:0]       n_lacc;

    assign sqx    = r_dx * r_dx;
    assign sqy    = r_dy * r_dy;
    assign rem_sh = {r_rem[REM_W-3:0], r_sq[SQ_W-1 -: 2]};
    assign trial  = {{(REM_W - R_W - 2){1'b0}}, r_root, 2'b01};
    assign sq_ge  = rem_sh >= trial;
    assign lsum   = SUM_W'(r_lacc) + SUM_W'(r_root);
    assign n_lacc = (lsum > SUM_W'(LEN_MAX)) ? LEN_MAX : lsum[LEN_W-1:0];

    // Division step
    logic            div_ge;
    logic [LEN_W:0]  div_rem;

    assign div_ge  = r_drem >= {1'b0, r_len};
    assign div_rem = div_ge ? r_drem - {1'b0, r_len} : r_drem;

    // RAM write muxing
    always_comb begin
        ctrl_we    = (r_state == S_CLR) || (wr_acc && idx_ok);
        ctrl_waddr = (r_state == S_CLR) ? r_clr : idx_a;
        ctrl_wx    = (r_state == S_CLR) ? '0 : COORD_WIDTH'($signed(i_in.data.point_x));
        ctrl_wy    = (r_state == S_CLR) ? '0 : COORD_WIDTH'($signed(i_in.data.point_y));
        len_we     = (r_state == S_CLR) || ((r_state == S_ACC) && (r_j == n_samp));
        len_waddr  = (r_state == S_CLR) ? r_clr : r_seg;
        len_wdata  = (r_state == S_CLR) ? '0 : n_lacc;
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_pts   <= PTS_RST;
            r_slog  <= SAMP_RST;
            r_ov    <= 1'b0;
            r_jj    <= '0;
            r_ph    <= '0;
            r_mode  <= MODE_LEN;
            r_grad  <= 1'b0;
            r_src   <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_POINTS)) begin
                r_pts <= i_cfg_data;
            end
            if (cfg_samp) begin
                r_slog <= i_cfg_data[3:0];
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + AW'(1);
                    if (int'(r_clr) == MAX_POINTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (cfg_samp) begin
                        r_seg   <= '0;
                        r_hi    <= AW'(SEG_COUNT - 1);
                        r_src   <= 1'b0;
                        r_state <= S_SEG;
                    end else if (wr_acc) begin
                        r_res <= '0;
                        if (idx_ok) begin
                            r_seg   <= wr_lo;
                            r_hi    <= wr_hi;
                            r_src   <= 1'b1;
                            r_state <= S_SEG;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end else if (qry_acc) begin
                        r_pos           <= i_in.data.arc_position;
                        r_seg           <= '0;
                        r_last          <= q_last;
                        r_res.beyond_end <= 1'b0;
                        r_mode          <= MODE_QRY;
                        r_grad          <= 1'b0;
                        r_state         <= S_WRD;
                    end
                end
                S_SEG: begin
                    r_j     <= '0;
                    r_lacc  <= '0;
                    r_t     <= '0;
                    r_mode  <= MODE_LEN;
                    r_grad  <= 1'b0;
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_tt    <= 33'(34'(r_t) * 34'(r_t));
                    r_state <= S_T3;
                end
                S_T3: begin
                    r_ttt   <= 33'((50'(r_tt) * 50'(r_t)) >> 16);
                    r_state <= S_W;
                end
                S_W: begin
                    for (int i = 0; i < 4; i++) begin
                        r_q[i] <= w[i];
                    end
                    r_ax    <= '0;
                    r_ay    <= '0;
                    r_ph    <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    // phase 0 waits for the point read at seg+jj
                    if (r_ph != 2'd0) begin
                        r_ax <= r_ax + addx;
                        r_ay <= r_ay + addy;
                    end
                    if (r_ph == 2'd2) begin
                        r_ph <= '0;
                        r_jj <= r_jj + 2'd1;
                        if (r_jj == 2'd3) begin
                            r_state <= S_EVD;
                        end
                    end else begin
                        r_ph <= r_ph + 2'd1;
                    end
                end
                S_EVD: begin
                    if (r_mode == MODE_LEN) begin
                        r_px <= rx;
                        r_py <= ry;
                        if (r_j == 9'd0) begin
                            r_j     <= 9'd1;
                            r_t     <= t_next;
                            r_state <= S_T2;
                        end else begin
                            r_dx    <= DW'(rx) - DW'(r_px);
                            r_dy    <= DW'(ry) - DW'(r_py);
                            r_state <= S_SQ1;
                        end
                    end else if (!r_grad) begin
                        r_res.curve_x <= sat_x16;
                        r_res.curve_y <= sat_y16;
                        r_grad        <= 1'b1;
                        r_state       <= S_T2;
                    end else begin
                        r_res.slope_x <= sat_x20;
                        r_res.slope_y <= sat_y20;
                        r_res.segment <= 4'(r_seg);
                        r_state       <= S_FIN;
                    end
                end
                S_SQ1: begin
                    r_sq    <= SQ_W'(sqx);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sq    <= r_sq + SQ_W'(sqy);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_scnt  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rem  <= sq_ge ? rem_sh - trial : rem_sh;
                    r_root <= {r_root[R_W-2:0], sq_ge};
                    r_sq   <= r_sq << 2;
                    r_scnt <= r_scnt + SC_W'(1);
                    if (int'(r_scnt) == R_W - 1) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_lacc <= n_lacc;
                    if (r_j == n_samp) begin
                        if (r_seg == r_hi) begin
                            r_state <= r_src ? S_FIN : S_IDLE;
                        end else begin
                            r_seg   <= r_seg + AW'(1);
                            r_state <= S_SEG;
                        end
                    end else begin
                        r_j     <= j_next;
                        r_t     <= t_next;
                        r_state <= S_T2;
                    end
                end
                S_WRD: begin
                    r_state <= S_WCMP;
                end
                S_WCMP: begin
                    if (r_pos > len_rdata) begin
                        if (r_seg == r_last) begin
                            r_res.beyond_end <= 1'b1;
                            r_t              <= T_ONE;
                            r_state          <= S_T2;
                        end else begin
                            r_pos   <= r_pos - len_rdata;
                            r_seg   <= r_seg + AW'(1);
                            r_state <= S_WRD;
                        end
                    end else if (len_rdata == '0) begin
                        r_t     <= '0;
                        r_state <= S_T2;
                    end else begin
                        r_len   <= len_rdata;
                        r_drem  <= {1'b0, r_pos};
                        r_qt    <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // rem <= len on entry, so the quotient fits in 17 bits
                    r_drem <= {div_rem[LEN_W-1:0], 1'b0};
                    r_qt   <= {r_qt[14:0], div_ge};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd16) begin
                        r_t     <= {r_qt, div_ge};
                        r_state <= S_T2;
                    end
                end
                S_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_od    <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/cral_chk.sv =====
// Port-level checker for catmull_rom_arc_length_path, bound to the top level.
// Depends on cral_pkg and catmull_rom_arc_length_path_macros.svh.
`include "catmull_rom_arc_length_path_macros.svh"

module cral_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input cral_pkg::t_out_item i_out_data
);
    import cral_pkg::*;

    // a stalled result beat stays put
    `CRAL_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `CRAL_ASSERT_RST(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_data))
    // clearing pass follows reset, so no beat is taken right after it
    `CRAL_ASSERT_ALWAYS(a_rst_busy, i_clk, !i_rst_n |=> !i_in_ready)
    // one item in flight: the block goes busy after taking a beat
    `CRAL_ASSERT_RST(a_one_item, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
endmodule

bind catmull_rom_arc_length_path cral_chk u_cral_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for catmull_rom_arc_length_path: random and directed point writes
// and arc position queries, checked against a behavioral path model kept in the bench.
// Depends on cral_pkg, cral_in_if, cral_out_if and the RTL top level.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import cral_pkg::*;

    localparam int  NPTS      = 16;
    localparam int  NSEG      = NPTS - 3;
    localparam int  LIMIT     = 8000000;
    localparam int  HOLD_LEN  = 2500;
    localparam int  MAX_SHOWN = 10;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic            i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    cral_in_if  in_ch ();
    cral_out_if out_ch ();

    catmull_rom_arc_length_path dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ---------------- path model ----------------
    longint          pt_x [NPTS];
    longint          pt_y [NPTS];
    longint unsigned arc_len [NPTS];
    int unsigned     path_pts;
    int unsigned     m_samples;

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // point (grad=0) or d/dt (grad=1) of segment seg at t (Q0.16), rounded to an integer
    function automatic void curve_at(input int seg, input longint t, input bit grad,
                                     output longint ox, output longint oy);
        longint tt, ttt, t32, one, sx, sy;
        longint w [4];
        tt  = t * t;
        ttt = (tt * t) >>> 16;
        t32 = t <<< 16;
        one = 64'sd1 <<< 32;
        if (!grad) begin
            w[0] = -ttt + 2 * tt - t32;
            w[1] = 3 * ttt - 5 * tt + 2 * one;
            w[2] = -3 * ttt + 4 * tt + t32;
            w[3] = ttt - tt;
        end else begin
            w[0] = -3 * tt + 4 * t32 - one;
            w[1] = 9 * tt - 10 * t32;
            w[2] = -9 * tt + 8 * t32 + one;
            w[3] = 3 * tt - 2 * t32;
        end
        sx = 0;
        sy = 0;
        for (int j = 0; j < 4; j++) begin
            sx = sx + pt_x[seg + j] * w[j];
            sy = sy + pt_y[seg + j] * w[j];
        end
        ox = (sx + (64'sd1 <<< 32)) >>> 33;
        oy = (sy + (64'sd1 <<< 32)) >>> 33;
    endfunction

    function automatic void measure_segment(input int s);
        int unsigned     k;
        longint          px, py, nx, ny, dx, dy;
        longint unsigned acc;
        k   = (m_samples > 8) ? 8 : m_samples;
        acc = 0;
        curve_at(s, 0, 1'b0, px, py);
        for (int j = 1; j <= (1 << k); j++) begin
            curve_at(s, longint'(j) <<< (16 - k), 1'b0, nx, ny);
            dx  = nx - px;
            dy  = ny - py;
            acc = acc + isqrt64(longint'(dx * dx) + longint'(dy * dy));
            if (acc > 64'hFFFFFF) acc = 64'hFFFFFF;
            px = nx;
            py = ny;
        end
        arc_len[s] = acc;
    endfunction

    function automatic longint sat_to(input longint v, input int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic int unsigned live_segments();
        int unsigned p;
        p = path_pts;
        if (p < 4) p = 4;
        if (p > NPTS) p = NPTS;
        return p - 3;
    endfunction

    function automatic longint unsigned path_total();
        longint unsigned sum;
        sum = 0;
        for (int s = 0; s < live_segments(); s++) sum = sum + arc_len[s];
        return sum;
    endfunction

    function automatic t_out_item path_step(input t_in_item it);
        t_out_item       r;
        int              idx, lo, hi, i;
        int unsigned     nseg;
        longint unsigned pos;
        bit              past;
        longint          t, cx, cy, gx, gy;
        r = '0;
        if (it.operation == OP_WRITE) begin
            idx = it.point_index;
            pt_x[idx] = longint'(it.point_x);
            pt_y[idx] = longint'(it.point_y);
            lo = (idx >= 3) ? idx - 3 : 0;
            hi = (idx < NSEG - 1) ? idx : NSEG - 1;
            for (int s = lo; s <= hi; s++) measure_segment(s);
            return r;
        end
        nseg = live_segments();
        pos  = 64'(it.arc_position);
        past = 1'b0;
        i    = 0;
        while (pos > arc_len[i]) begin
            if (i + 1 >= nseg) begin
                past = 1'b1;
                break;
            end
            pos = pos - arc_len[i];
            i++;
        end
        if (past) t = 65536;
        else if (arc_len[i] == 0) t = 0;
        else t = longint'((pos << 16) / arc_len[i]);
        curve_at(i, t, 1'b0, cx, cy);
        curve_at(i, t, 1'b1, gx, gy);
        r.curve_x    = 16'(sat_to(cx, 16));
        r.curve_y    = 16'(sat_to(cy, 16));
        r.slope_x    = 20'(sat_to(gx, 20));
        r.slope_y    = 20'(sat_to(gy, 20));
        r.segment    = i[3:0];
        r.beyond_end = past;
        return r;
    endfunction

    // ---------------- driver / monitor ----------------
    t_in_item  pending_beats [$];
    t_out_item expected_results [$];
    bit        calm;
    bit        hold_go;
    int        hold_left;
    int        cycles;
    int        mismatches;
    int        n_checked, n_writes, n_queries, n_past;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(path_step(in_ch.data));
                if (in_ch.data.operation == OP_WRITE) n_writes++;
                else n_queries++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 25)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_beats.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_go && hold_left == 0) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left > 1) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (hold_left > 1) ? 1'b0 :
                            (calm || $urandom_range(99) >= 25);
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result beat: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (want.beyond_end) n_past++;
                    if (got.curve_x !== want.curve_x || got.curve_y !== want.curve_y ||
                        got.slope_x !== want.slope_x || got.slope_y !== want.slope_y ||
                        got.segment !== want.segment ||
                        got.beyond_end !== want.beyond_end) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch beat %0d: exp %p got %p",
                                     n_checked, want, got);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_in_item wr_beat(input int idx, input int x, input int y);
        t_in_item it;
        it             = '0;
        it.operation   = OP_WRITE;
        it.point_index = idx[3:0];
        it.point_x     = x[15:0];
        it.point_y     = y[15:0];
        it.arc_position = 24'($urandom);
        return it;
    endfunction

    function automatic t_in_item qry_beat(input longint unsigned pos);
        t_in_item it;
        it              = '0;
        it.operation    = OP_QUERY;
        it.point_index  = 4'($urandom);
        it.point_x      = 16'($urandom);
        it.point_y      = 16'($urandom);
        it.arc_position = pos[23:0];
        return it;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 32767 : -32768;
            1:       return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(8000)) - 4000;
        endcase
    endfunction

    function automatic t_in_item rand_beat();
        longint unsigned tot;
        tot = path_total();
        if ($urandom_range(2) == 0)
            return wr_beat($urandom_range(live_segments() + 2) % NPTS,
                           rand_coord(), rand_coord());
        case ($urandom_range(9))
            0:       return qry_beat($urandom);
            1:       return qry_beat(tot + $urandom_range(50));
            2:       return qry_beat(tot);
            default: return qry_beat(tot == 0 ? 0 : ($urandom % (tot + 1)));
        endcase
    endfunction

    task automatic cfg_write(input logic idx, input int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_W-1:0];
        if (idx == CFG_POINTS) begin
            path_pts = val & 5'h1F;
        end else begin
            m_samples = val & 4'hF;
            for (int s = 0; s < NSEG; s++) measure_segment(s);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // let all beats and results drain, then the tail of any length recompute
    task automatic drain();
        int k;
        while (pending_beats.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge i_clk);
        k = (m_samples > 8) ? 8 : m_samples;
        repeat (14 * ((1 << k) + 1) * 64 + 300) @(posedge i_clk);
    endtask

    int ph_points  [8] = '{16, 31, 2, 7, 16, 10, 5, 16};
    int ph_samples [8] = '{1, 0, 2, 15, 3, 0, 1, 2};
    int ph_items   [8] = '{170, 150, 150, 8, 120, 180, 180, 200};

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_POINTS;
        i_cfg_data  = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
        calm = 1'b0;
        hold_go = 1'b0;
        cycles = 0;
        mismatches = 0;
        n_checked = 0;
        n_writes = 0;
        n_queries = 0;
        n_past = 0;
        for (int i = 0; i < NPTS; i++) begin
            pt_x[i] = 0;
            pt_y[i] = 0;
            arc_len[i] = 0;
        end
        path_pts  = PTS_RST;
        m_samples = SAMP_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero path, extremes, repeated points, end of path
        pending_beats.push_back(qry_beat(0));
        pending_beats.push_back(qry_beat(1));
        pending_beats.push_back(qry_beat(24'hFFFFFF));
        pending_beats.push_back(wr_beat(0, -32768, 32767));
        pending_beats.push_back(wr_beat(1, 32767, -32768));
        pending_beats.push_back(wr_beat(2, -32768, -32768));
        pending_beats.push_back(wr_beat(3, 32767, 32767));
        pending_beats.push_back(qry_beat(0));
        pending_beats.push_back(qry_beat(24'hFFFFFF));
        pending_beats.push_back(wr_beat(15, 32767, 32767));
        pending_beats.push_back(wr_beat(1, 0, 0));
        pending_beats.push_back(wr_beat(2, 0, 0));
        pending_beats.push_back(wr_beat(0, 0, 0));
        pending_beats.push_back(wr_beat(3, 0, 0));
        pending_beats.push_back(qry_beat(5));
        pending_beats.push_back(wr_beat(0, 0, 0));
        pending_beats.push_back(wr_beat(1, 160, 0));
        pending_beats.push_back(wr_beat(2, 320, 160));
        pending_beats.push_back(wr_beat(3, 480, -160));
        drain();
        // exact end of the path, then just past it
        pending_beats.push_back(qry_beat(path_total()));
        pending_beats.push_back(qry_beat(path_total() + 1));
        pending_beats.push_back(qry_beat(path_total() / 2));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            cfg_write(CFG_POINTS, ph_points[ph]);
            cfg_write(CFG_SAMPLES, ph_samples[ph]);
            calm = (ph == 2);
            for (int n = 0; n < ph_items[ph]; n++) pending_beats.push_back(rand_beat());
            if (ph == 1) begin
                // receiver stalls long while the sender keeps offering beats
                @(posedge i_clk);
                hold_go <= 1'b1;
                @(posedge i_clk);
                hold_go <= 1'b0;
            end
            drain();
        end
        calm = 1'b0;

        repeat (200) @(posedge i_clk);
        $display("checked %0d result beats: %0d point writes, %0d queries, %0d past the end",
                 n_checked, n_writes, n_queries, n_past);
        $display("path sizes 4..16 with clamping, length sampling 1..256 chords, %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== catmull_rom_arc_length_path.f =====
+incdir+rtl
rtl/cral_pkg.sv
rtl/cral_in_if.sv
rtl/cral_out_if.sv
rtl/cral_ram.sv
rtl/catmull_rom_arc_length_path.sv
rtl/cral_chk.sv
tb/tb_top.sv
